FILE: rtl/lphm_pkg.sv
// Shared types, constants and hash helpers for the linear-probe hash map.
package lphm_pkg;

	localparam int SLOTS   = 1024;
	localparam int IDX_W   = $clog2(SLOTS);
	localparam int CNT_W   = IDX_W + 1;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int FULL_AT = SLOTS * 3 / 4;

	localparam logic [31:0] HASH_C1 = 32'h85eb_ca6b;
	localparam logic [31:0] HASH_C2 = 32'hc2b2_ae35;

	typedef enum logic [1:0] {
		F_LOOKUP = 2'd0,
		F_INSERT = 2'd1,
		F_DELETE = 2'd2,
		F_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_ABSENT = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef struct packed {
		logic load;
		logic hash_a;
		logic hash_src_rd;
		logic hash_b;
		logic probe_start;
		logic rd_probe;
		logic chk;
		logic rd_del;
		logic del_step;
		logic del_finish;
		logic zero_op;
		logic clr_start;
		logic clr_step;
	} dp_cmd_t;

	typedef struct packed {
		func_t func;
		logic  key_zero;
		logic  hit;
		logic  empty;
		logic  probe_last;
		logic  del_end;
		logic  clr_last;
	} dp_sts_t;

endpackage

FILE: rtl/lphm_if.sv
// Request and response channel interfaces of the hash map.
interface lphm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [31:0] key;
	logic [31:0] value;
	modport source (output valid, func, key, value, input ready);
	modport sink (input valid, func, key, value, output ready);
endinterface

interface lphm_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        found;
	logic [31:0] old_value;
	modport source (output valid, status, found, old_value, input ready);
	modport sink (input valid, status, found, old_value, output ready);
endinterface

FILE: rtl/lphm_datapath.sv
// Hash map datapath: slot memory, shared hash unit, probe and repair registers, counters.
module lphm_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lphm_pkg::dp_cmd_t      cmd,
	output lphm_pkg::dp_sts_t      sts,
	input  logic [1:0]             in_func,
	input  logic [lphm_pkg::KEY_W-1:0] in_key,
	input  logic [lphm_pkg::VAL_W-1:0] in_value,
	output logic [1:0]             res_status,
	output logic                   res_found,
	output logic [lphm_pkg::VAL_W-1:0] res_old_value
);
	import lphm_pkg::*;

	logic [KEY_W+VAL_W-1:0] mem [SLOTS];

	func_t              func_q;
	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   val_q;
	logic [KEY_W-1:0]   rd_key_q;
	logic [VAL_W-1:0]   rd_val_q;
	logic [31:0]        m1_s1;
	logic [31:0]        m2_s2;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   hole_q;
	logic [IDX_W-1:0]   j_q;
	logic [CNT_W-1:0]   n_q;
	logic [IDX_W-1:0]   clr_idx_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               zkey_held_q;
	logic [VAL_W-1:0]   zero_val_q;
	status_t            status_q;
	logic               found_q;
	logic [VAL_W-1:0]   old_q;

	logic [31:0]        hash_x;
	logic [31:0]        hash_a_in;
	logic [31:0]        hash_b_in;
	logic [IDX_W-1:0]   home;
	logic               hit;
	logic               empty;
	logic               last;
	logic               full;
	logic               we;
	logic [IDX_W-1:0]   waddr;
	logic [KEY_W+VAL_W-1:0] wdata;
	logic               shift_ok;

	assign hash_x    = cmd.hash_src_rd ? rd_key_q : key_q;
	assign hash_a_in = hash_x ^ (hash_x >> 16);
	assign hash_b_in = m1_s1 ^ (m1_s1 >> 13);
	assign home      = IDX_W'(m2_s2 ^ (m2_s2 >> 16));

	assign hit   = (rd_key_q == key_q);
	assign empty = (rd_key_q == '0);
	assign last  = (n_q == CNT_W'(SLOTS - 1));
	assign full  = ((cnt_q + CNT_W'(1)) >= CNT_W'(FULL_AT));
	// cyclic distance from the home slot
	assign shift_ok = ((hole_q - home) < (j_q - home));

	assign sts.func       = func_q;
	assign sts.key_zero   = (key_q == '0);
	assign sts.hit        = hit;
	assign sts.empty      = empty;
	assign sts.probe_last = last;
	assign sts.del_end    = (n_q == CNT_W'(SLOTS)) || empty;
	assign sts.clr_last   = (clr_idx_q == IDX_W'(SLOTS - 1));

	assign res_status    = status_q;
	assign res_found     = found_q;
	assign res_old_value = old_q;

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = {key_q, val_q};
		if (cmd.clr_step) begin
			we    = 1'b1;
			waddr = clr_idx_q;
			wdata = '0;
		end else if (cmd.chk) begin
			if (hit) begin
				we = (func_q == F_INSERT);
			end else if (empty) begin
				we = (func_q == F_INSERT) && !full;
			end
		end else if (cmd.del_step) begin
			we    = shift_ok;
			waddr = hole_q;
			wdata = {rd_key_q, rd_val_q};
		end else if (cmd.del_finish) begin
			we    = 1'b1;
			waddr = hole_q;
			wdata = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_probe) begin
			{rd_key_q, rd_val_q} <= mem[idx_q];
		end else if (cmd.rd_del) begin
			{rd_key_q, rd_val_q} <= mem[j_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_t'(in_func);
			key_q  <= in_key;
			val_q  <= in_value;
		end
		if (cmd.hash_a) begin
			m1_s1 <= 32'(hash_a_in * HASH_C1);
		end
		if (cmd.hash_b) begin
			m2_s2 <= 32'(hash_b_in * HASH_C2);
		end
		if (cmd.probe_start) begin
			idx_q <= home;
			n_q   <= '0;
		end
		if (cmd.chk) begin
			found_q <= hit;
			old_q   <= hit ? rd_val_q : '0;
			if (hit) begin
				status_q <= ST_DONE;
				hole_q   <= idx_q;
				j_q      <= idx_q + IDX_W'(1);
				n_q      <= CNT_W'(1);
			end else if (empty) begin
				if (func_q == F_INSERT) begin
					status_q <= full ? ST_FULL : ST_DONE;
				end else begin
					status_q <= ST_ABSENT;
				end
			end else if (last) begin
				status_q <= (func_q == F_INSERT) ? ST_FULL : ST_ABSENT;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
				n_q   <= n_q + CNT_W'(1);
			end
		end
		if (cmd.del_step) begin
			if (shift_ok) begin
				hole_q <= j_q;
			end
			j_q <= j_q + IDX_W'(1);
			n_q <= n_q + CNT_W'(1);
		end
		if (cmd.zero_op) begin
			found_q <= zkey_held_q;
			old_q   <= zkey_held_q ? zero_val_q : '0;
			if (func_q == F_LOOKUP || func_q == F_DELETE) begin
				status_q <= zkey_held_q ? ST_DONE : ST_ABSENT;
			end else begin
				status_q <= ST_DONE;
			end
		end
		if (cmd.clr_start) begin
			status_q <= ST_DONE;
			found_q  <= 1'b0;
			old_q    <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			zkey_held_q <= 1'b0;
			zero_val_q  <= '0;
			clr_idx_q   <= '0;
		end else begin
			if (cmd.clr_start) begin
				cnt_q       <= '0;
				zkey_held_q <= 1'b0;
				zero_val_q  <= '0;
				clr_idx_q   <= '0;
			end
			if (cmd.clr_step) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
			end
			if (cmd.chk && !hit && empty && func_q == F_INSERT && !full) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.del_finish) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.zero_op) begin
				if (func_q == F_INSERT) begin
					zkey_held_q <= 1'b1;
					zero_val_q  <= val_q;
					if (!zkey_held_q) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end else if (func_q == F_DELETE && zkey_held_q) begin
					zkey_held_q <= 1'b0;
					zero_val_q  <= '0;
					cnt_q       <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

endmodule

FILE: rtl/lphm_ctrl.sv
// Hash map controller: sequences clear sweeps, hashing, probing and delete repair.
module lphm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output lphm_pkg::dp_cmd_t cmd,
	input  lphm_pkg::dp_sts_t sts
);
	import lphm_pkg::*;

	typedef enum logic [13:0] {
		S_CLR  = 14'b00000000000001,
		S_IDLE = 14'b00000000000010,
		S_DISP = 14'b00000000000100,
		S_H2   = 14'b00000000001000,
		S_PSET = 14'b00000000010000,
		S_RD   = 14'b00000000100000,
		S_CHK  = 14'b00000001000000,
		S_DRD  = 14'b00000010000000,
		S_DCHK = 14'b00000100000000,
		S_DH2  = 14'b00001000000000,
		S_DCMP = 14'b00010000000000,
		S_RESP = 14'b00100000000000,
		S_ZERO = 14'b01000000000000,
		S_DH1  = 14'b10000000000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   clr_resp_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_RESP);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = clr_resp_q ? S_RESP : S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.func == F_CLEAR) begin
					cmd.clr_start = 1'b1;
					state_d       = S_CLR;
				end else if (sts.key_zero) begin
					state_d = S_ZERO;
				end else begin
					cmd.hash_a = 1'b1;
					state_d    = S_H2;
				end
			end
			S_ZERO: begin
				cmd.zero_op = 1'b1;
				state_d     = S_RESP;
			end
			S_H2: begin
				cmd.hash_b = 1'b1;
				state_d    = S_PSET;
			end
			S_PSET: begin
				cmd.probe_start = 1'b1;
				state_d         = S_RD;
			end
			S_RD: begin
				cmd.rd_probe = 1'b1;
				state_d      = S_CHK;
			end
			S_CHK: begin
				cmd.chk = 1'b1;
				if (sts.hit && sts.func == F_DELETE) begin
					state_d = S_DRD;
				end else if (sts.hit || sts.empty || sts.probe_last) begin
					state_d = S_RESP;
				end else begin
					state_d = S_RD;
				end
			end
			S_DRD: begin
				cmd.rd_del = 1'b1;
				state_d    = S_DCHK;
			end
			S_DCHK: begin
				if (sts.del_end) begin
					cmd.del_finish = 1'b1;
					state_d        = S_RESP;
				end else begin
					state_d = S_DH1;
				end
			end
			S_DH1: begin
				cmd.hash_a      = 1'b1;
				cmd.hash_src_rd = 1'b1;
				state_d         = S_DH2;
			end
			S_DH2: begin
				cmd.hash_b = 1'b1;
				state_d    = S_DCMP;
			end
			S_DCMP: begin
				cmd.del_step = 1'b1;
				state_d      = S_DRD;
			end
			S_RESP: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_resp_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.clr_start) begin
				clr_resp_q <= 1'b1;
			end
		end
	end

endmodule

FILE: rtl/linear_probe_hash_map_unit.sv
// Integer-key hash map with linear probing, one operation per request word.
// After reset the block sweeps its 1024-slot store to empty before it takes the
// first request. Each request is a lookup, insert-or-update, delete or clear and
// yields one response word; one request is in flight at a time. A nonzero-key
// operation hashes the key, then reads and compares one slot at a time from the
// home slot onward; a delete that hits then scans the following occupied slots for
// the backward-shift repair, rehashing each scanned key through the shared
// two-multiplier hash unit, until a slot ends the scan. Key zero skips hashing and
// probing; a clear sweeps every slot to empty.
// The response waits until taken, then the block returns to idle.
module linear_probe_hash_map_unit (
	input  logic clk,
	input  logic arst_n,
	lphm_req_if.sink   req,
	lphm_rsp_if.source rsp
);
	import lphm_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	lphm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	lphm_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_func       (req.func),
		.in_key        (req.key),
		.in_value      (req.value),
		.res_status    (rsp.status),
		.res_found     (rsp.found),
		.res_old_value (rsp.old_value)
	);

endmodule

FILE: rtl/lphm_checker.sv
// Port-level checks of the hash map unit, bound to the top level.
module lphm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic        rsp_found,
	input logic [31:0] rsp_old_value
);
	import lphm_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response word dropped while stalled");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status != 2'd3)
		else $error("illegal status code");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request taken while response pending");

	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_DONE |-> !rsp_found && rsp_old_value == '0)
		else $error("failed operation reports an old value");

	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken back to back");

endmodule

bind linear_probe_hash_map_unit lphm_checker u_lphm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.rsp_found     (rsp.found),
	.rsp_old_value (rsp.old_value)
);
